// ===== sv/elx_pkg.sv =====
package elx_pkg;

  localparam int unsigned MAX_CHARS = 4096;
  localparam int unsigned POS_W     = $clog2(MAX_CHARS + 1);
  localparam int unsigned FIELD_W   = 13;
  localparam int unsigned GRP_N     = 3;

  localparam logic [31:0] HASH_MUL = 32'h811C9DC5;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FIELD_W-1:0] field_pos_t;

  localparam pos_t POS_MAX = POS_W'(MAX_CHARS);

  typedef enum logic [3:0] {
    K_END     = 4'd0,
    K_UNKNOWN = 4'd1,
    K_IDENT   = 4'd2,
    K_PLUS    = 4'd3,
    K_MINUS   = 4'd4,
    K_ARROW   = 4'd5,
    K_STAR    = 4'd6,
    K_SLASH   = 4'd7,
    K_NOT     = 4'd8,
    K_TILDE   = 4'd9,
    K_LPAREN  = 4'd10,
    K_RPAREN  = 4'd11,
    K_COMMA   = 4'd12
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    field_pos_t  start_pos;
    field_pos_t  stop_pos;
    logic [31:0] ident_hash;
  } tok_t;

  typedef struct packed {
    tok_t [GRP_N-1:0] tok;
    logic [1:0]       cnt;
  } group_t;

  function automatic logic word_byte(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F};
  endfunction

  function automatic kind_e single_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_BANG:   k = K_NOT;
      CH_TILDE:  k = K_TILDE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_COMMA:  k = K_COMMA;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input kind_e k, input pos_t start, input pos_t stop,
                                  input logic [31:0] hash);
    tok_t t;
    t.kind       = k;
    t.start_pos  = FIELD_W'(start);
    t.stop_pos   = FIELD_W'(stop);
    t.ident_hash = hash;
    return t;
  endfunction

endpackage

// ===== sv/elx_in_if.sv =====
interface elx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_byte;

  modport source (output valid, output ch, output final_byte, input ready);
  modport sink (input valid, input ch, input final_byte, output ready);
endinterface

// ===== sv/elx_out_if.sv =====
interface elx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [12:0] start_pos;
  logic [12:0] stop_pos;
  logic [31:0] ident_hash;
  logic        run_last;

  modport source (output valid, output kind, output start_pos, output stop_pos,
                  output ident_hash, output run_last, input ready);
  modport sink (input valid, input kind, input start_pos, input stop_pos,
                input ident_hash, input run_last, output ready);
endinterface

// ===== sv/elx_core.sv =====
module elx_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  elx_in_if.sink          in_i,
  input  logic            accept_ok_i,
  output elx_pkg::group_t grp_o,
  output logic            grp_push_o
);
  import elx_pkg::*;

  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_IDENT = 2'd1,
    P_MINUS = 2'd2
  } pend_e;

  pend_e       pend_q, pend_d;
  pos_t        pos_q, pos_d;
  pos_t        pstart_q, pstart_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] hmul;
  logic        fire;

  assign in_i.ready = accept_ok_i;
  assign fire       = in_i.valid && accept_ok_i;
  assign hmul       = hash_q * HASH_MUL;

  always_comb begin
    logic [7:0] c;
    logic       wb;
    logic       fresh;
    pos_t       p;
    pos_t       nxt;
    logic [1:0] n;
    tok_t [GRP_N-1:0] t;

    c     = in_i.ch;
    wb    = word_byte(c);
    p     = pos_q;
    nxt   = (p < POS_MAX) ? p + pos_t'(1) : POS_MAX;
    fresh = 1'b1;
    n     = 2'd0;
    t     = '0;

    pend_d   = P_NONE;
    pstart_d = pstart_q;
    hash_d   = hash_q;

    case (pend_q)
      P_IDENT: begin
        if (wb) begin
          hash_d = hmul ^ {24'd0, c};
          fresh  = 1'b0;
          pend_d = P_IDENT;
        end else begin
          t[n] = mk_tok(K_IDENT, pstart_q, p, hash_q);
          n    = n + 2'd1;
        end
      end
      P_MINUS: begin
        if (c == CH_GT) begin
          t[n]  = mk_tok(K_ARROW, pstart_q, nxt, 32'd0);
          fresh = 1'b0;
        end else begin
          t[n] = mk_tok(K_MINUS, pstart_q, p, 32'd0);
        end
        n = n + 2'd1;
      end
      default: pend_d = P_NONE;
    endcase

    if (fresh && c != CH_SPACE) begin
      if (wb) begin
        pend_d   = P_IDENT;
        pstart_d = p;
        hash_d   = {24'd0, c};
      end else if (c == CH_MINUS) begin
        pend_d   = P_MINUS;
        pstart_d = p;
      end else begin
        t[n] = mk_tok(single_kind(c), p, nxt, 32'd0);
        n    = n + 2'd1;
      end
    end

    pos_d = nxt;

    if (in_i.final_byte) begin
      if (pend_d == P_IDENT) begin
        t[n] = mk_tok(K_IDENT, pstart_d, nxt, hash_d);
        n    = n + 2'd1;
      end else if (pend_d == P_MINUS) begin
        t[n] = mk_tok(K_MINUS, pstart_d, nxt, 32'd0);
        n    = n + 2'd1;
      end
      t[n]     = mk_tok(K_END, nxt, nxt, 32'd0);
      n        = n + 2'd1;
      pend_d   = P_NONE;
      pos_d    = '0;
      pstart_d = '0;
      hash_d   = '0;
    end

    grp_o.tok = t;
    grp_o.cnt = n;
  end

  assign grp_push_o = fire && (grp_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= P_NONE;
      pos_q    <= '0;
      pstart_q <= '0;
      hash_q   <= '0;
    end else if (fire) begin
      pend_q   <= pend_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      hash_q   <= hash_d;
    end
  end

endmodule

// ===== sv/elx_drain.sv =====
module elx_drain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  elx_pkg::group_t grp_i,
  input  logic            grp_push_i,
  output logic            accept_ok_o,
  elx_out_if.source       out_o
);
  import elx_pkg::*;

  tok_t [GRP_N-1:0] tok_q;
  logic [1:0]       rem_q, rem_d;
  logic [1:0]       idx_q, idx_d;
  logic             pop;
  tok_t             cur;

  assign pop         = out_o.valid && out_o.ready;
  assign accept_ok_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_o.ready);

  assign cur              = tok_q[idx_q];
  assign out_o.valid      = (rem_q != 2'd0);
  assign out_o.kind       = cur.kind;
  assign out_o.start_pos  = cur.start_pos;
  assign out_o.stop_pos   = cur.stop_pos;
  assign out_o.ident_hash = cur.ident_hash;
  assign out_o.run_last   = (rem_q == 2'd1);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (grp_push_i) begin
      rem_d = grp_i.cnt;
      idx_d = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_push_i) begin
      tok_q <= grp_i.tok;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3)
    else $error("drain index past group end");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(idx_q) && $stable(rem_q))
    else $error("drain moved while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == 2'd0) && !grp_push_i |=> (rem_q == 2'd0))
    else $error("word appeared without a push");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (cur.kind == K_END) |-> out_o.run_last)
    else $error("end token not last of its group");

  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_push_i |-> accept_ok_o)
    else $error("push into busy drain");
`endif

endmodule

// ===== sv/expression_lexer_with_ident_hash_top.sv =====
// channel  dir  modport  payload
// in_i     in   sink     ch[7:0], final_byte
// out_o    out  source   kind[3:0], start_pos[12:0], stop_pos[12:0], ident_hash[31:0], run_last
//
// A byte is taken every cycle while it yields at most one word and the output is not stalled;
// a byte that yields k words (k <= 3) holds off the next byte while the drain stage sends
// them out one per cycle while the output is not stalled. The identifier hash update (one
// 32x32 constant multiply and XOR) sits in the combinational logic ahead of the state
// registers. Reset clears position, pending token and hash. Output stalls hold the word;
// input is taken when the drain holds no word or its last word leaves in the same cycle.
module expression_lexer_with_ident_hash_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  elx_in_if.sink    in_i,
  elx_out_if.source out_o
);
  import elx_pkg::*;

  group_t grp;
  logic   grp_push;
  logic   accept_ok;

  elx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .accept_ok_i (accept_ok),
    .grp_o       (grp),
    .grp_push_o  (grp_push)
  );

  elx_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .grp_push_i  (grp_push),
    .accept_ok_o (accept_ok),
    .out_o       (out_o)
  );

endmodule
